@@ rtl/mlrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlrs_pkg: shared types and constants of the lowest-RTT path scheduler
// Request and result payloads, codes, and the links between the scan
// controller and the mean-RTT unit.
// ----------------------------------------------------------------------------
package mlrs_pkg;

  localparam int MAX_SENDING   = 8;
  localparam int MAX_RECEIVING = 8;
  localparam int SEND_W        = $clog2(MAX_SENDING);
  localparam int RECV_W        = $clog2(MAX_RECEIVING);
  localparam int SCNT_W        = $clog2(MAX_SENDING + 1);
  localparam int RCNT_W        = $clog2(MAX_RECEIVING + 1);
  localparam int PAIR_AW       = SEND_W + RECV_W;
  localparam int PAIR_DEPTH    = MAX_SENDING * MAX_RECEIVING;

  localparam int RTT_W   = 32;
  localparam int SMP_W   = 24;
  localparam int PROD_W  = RTT_W + SMP_W;
  localparam int WSUM_W  = PROD_W + RCNT_W - 1;
  localparam int NSUM_W  = SMP_W + RCNT_W - 1;
  localparam int QCNT_W  = $clog2(RTT_W);

  localparam logic [7:0] NO_INDEX = 8'd255;

  // func codes
  localparam logic [1:0] FN_SCHED = 2'd0;
  localparam logic [1:0] FN_UF_WR = 2'd1;
  localparam logic [1:0] FN_PR_WR = 2'd2;

  // retransmit kinds
  localparam logic [1:0] RK_TIMEOUT = 2'd1;
  localparam logic [1:0] RK_FAST    = 2'd2;

  // decisions
  localparam logic [2:0] DEC_STAY     = 3'd0;
  localparam logic [2:0] DEC_CHANGE   = 3'd1;
  localparam logic [2:0] DEC_RETX     = 3'd2;
  localparam logic [2:0] DEC_BEST     = 3'd3;
  localparam logic [2:0] DEC_DEFAULT  = 3'd4;
  localparam logic [2:0] DEC_WR_DONE  = 3'd5;

  // config register indexes
  localparam logic CFG_SENDING   = 1'b0;
  localparam logic CFG_RECEIVING = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  send_index;
    logic [2:0]  recv_index;
    logic        active_flag;
    logic        verified_flag;
    logic [31:0] window_bytes;
    logic [31:0] in_flight_bytes;
    logic [31:0] rtt_value;
    logic [23:0] sample_count;
    logic [1:0]  retransmit_kind;
    logic [2:0]  source_uniflow;
    logic        want_change;
  } req_t;

  typedef struct packed {
    logic [2:0]  chosen_uniflow;
    logic [2:0]  decision;
    logic [31:0] chosen_rtt;
  } rsp_t;

  typedef struct packed {
    logic        active;
    logic        verified;
    logic [31:0] window;
    logic [31:0] in_flight;
  } uf_ent_t;

  typedef struct packed {
    logic [RTT_W-1:0] rtt;
    logic [SMP_W-1:0] samples;
  } pair_ent_t;

  typedef struct packed {
    logic               en;
    logic [PAIR_AW-1:0] addr;
    pair_ent_t          data;
  } pair_wr_t;

  typedef struct packed {
    logic              start;
    logic [SEND_W-1:0] send;
    logic [RCNT_W-1:0] nrecv;
  } mean_cmd_t;

  typedef struct packed {
    logic             done;
    logic [RTT_W-1:0] mean;
  } mean_sts_t;

  typedef enum logic [2:0] {
    M_IDLE, M_READ, M_MUL, M_ACC, M_DIV, M_FIN
  } mean_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EVAL, S_MEAN, S_END, S_DONE
  } scan_state_t;

endpackage

@@ rtl/multipath_lowest_rtt_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// multipath_lowest_rtt_scheduler_unit: lowest-RTT sending path scheduler
// Scans sending uniflows and picks at most one per schedule request;
// a fast-retransmit request stays on its source uniflow without a scan.
// Usage:
//   in_*  : request channel (valid/stall). func selects schedule, uniflow
//           status write or pair RTT stats write.
//   out_* : one result per request (valid/stall).
//   cfg_* : register writes (valid/ready, always ready); index 0 is
//           sending_count, 1 is receiving_count. Write only while idle.
// Flow:
//   writes, fast-retransmit and stay requests go straight to the output reg.
//   schedule scan: each uniflow is read, then evaluated; a uniflow that needs
//   its mean RTT runs the mean unit: read, multiply and accumulate per
//   receiving uniflow, then the bit-serial divider and its finish state.
//   One request at a time; the next is taken as soon as the result moved
//   into the output register, even while the receiver stalls it.
// Reset: sync, active high. Counts return to 1, all status and pair
//   stats read as zero (per-entry valid bits), last used path is none.
// Stall: the output register holds; the scan finishes and waits for it.
// ----------------------------------------------------------------------------
module multipath_lowest_rtt_scheduler_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mlrs_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mlrs_pkg::rsp_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [3:0]      cfg_data
);
  import mlrs_pkg::*;

  // uniflow status store
  uf_ent_t                uf_mem [MAX_SENDING];
  logic [MAX_SENDING-1:0] uf_vld;
  uf_ent_t                uf_q;
  logic                   uf_ok;
  uf_ent_t                uf;
  logic                   uf_rd;

  logic [3:0]             sending_count;
  logic [3:0]             receiving_count;
  logic [SCNT_W-1:0]      nsend;
  logic [RCNT_W-1:0]      nrecv;

  scan_state_t            state, state_next;
  req_t                   req;
  logic                   accept;
  logic [SCNT_W-1:0]      i;
  logic                   last_i;
  logic                   mean_for_change;
  logic                   sel_ok;
  logic [SEND_W-1:0]      sel;
  logic [2:0]             dec;
  logic [RTT_W-1:0]       res_rtt;
  logic                   best_ok;
  logic [RTT_W-1:0]       best;
  logic [7:0]             last_used;
  rsp_t                   res;
  logic                   out_free;
  logic                   out_load;

  // evaluation of the uniflow currently read
  logic                   ev_change, ev_full, ev_retx, ev_best;

  pair_wr_t               pair_wr;
  mean_cmd_t              mcmd;
  mean_sts_t              msts;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign nsend = (sending_count > 4'(MAX_SENDING)) ? SCNT_W'(MAX_SENDING)
                                                   : SCNT_W'(sending_count);
  assign nrecv = (receiving_count > 4'(MAX_RECEIVING)) ? RCNT_W'(MAX_RECEIVING)
                                                       : RCNT_W'(receiving_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      sending_count   <= 4'd1;
      receiving_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SENDING:   sending_count   <= cfg_data;
        CFG_RECEIVING: receiving_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // status store: written only on an accepted request, read only during a scan
  always_ff @(posedge clk) begin
    if (accept && in_data.func == FN_UF_WR) begin
      uf_mem[in_data.send_index] <= '{in_data.active_flag, in_data.verified_flag,
                                      in_data.window_bytes, in_data.in_flight_bytes};
    end
    if (uf_rd) uf_q <= uf_mem[i[SEND_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uf_vld <= '0;
      uf_ok  <= 1'b0;
    end else begin
      if (accept && in_data.func == FN_UF_WR) uf_vld[in_data.send_index] <= 1'b1;
      if (uf_rd) uf_ok <= uf_vld[i[SEND_W-1:0]];
    end
  end

  assign uf = uf_ok ? uf_q : '0;

  assign pair_wr.en   = accept && in_data.func == FN_PR_WR;
  assign pair_wr.addr = {in_data.recv_index, in_data.send_index};
  assign pair_wr.data = '{in_data.rtt_value, in_data.sample_count};

  mlrs_mean u_mean (
    .clk (clk),
    .rst (rst),
    .wr  (pair_wr),
    .cmd (mcmd),
    .sts (msts)
  );

  // scan rules in priority order
  assign ev_change = uf.active && req.want_change && ({5'd0, i[SEND_W-1:0]} != last_used);
  assign ev_full   = uf.window <= uf.in_flight;
  assign ev_retx   = uf.active && !ev_change && !ev_full &&
                     req.retransmit_kind == RK_TIMEOUT &&
                     i[SEND_W-1:0] == req.source_uniflow;
  assign ev_best   = uf.active && !ev_change && !ev_full && !ev_retx && uf.verified;
  assign last_i    = (i + 1'b1) == nsend;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (in_data.func != FN_SCHED || in_data.retransmit_kind == RK_FAST) begin
          state_next = S_DONE;
        end else begin
          state_next = (nsend == '0) ? S_END : S_RD;
        end
      end
      S_RD:   state_next = S_EVAL;
      S_EVAL: begin
        if (ev_change || ev_best) state_next = S_MEAN;
        else if (ev_retx || last_i) state_next = S_END;
        else state_next = S_RD;
      end
      S_MEAN: if (msts.done) begin
        if (mean_for_change || last_i) state_next = S_END;
        else state_next = S_RD;
      end
      S_END:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    uf_rd      = 1'b0;
    mcmd.start = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: in_stall = 1'b0;
      S_RD:   uf_rd = 1'b1;
      S_EVAL: mcmd.start = ev_change || ev_best;
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign mcmd.send  = i[SEND_W-1:0];
  assign mcmd.nrecv = nrecv;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_used <= NO_INDEX;
    end else if (state == S_END) begin
      last_used <= sel_ok ? {5'd0, sel} : NO_INDEX;
    end
  end

  // scan bookkeeping and result assembly
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        req     <= in_data;
        i       <= '0;
        sel_ok  <= 1'b0;
        best_ok <= 1'b0;
        dec     <= DEC_DEFAULT;
        res_rtt <= '0;
        if (in_data.func != FN_SCHED) begin
          res <= '{3'd0, DEC_WR_DONE, 32'd0};
        end else if (in_data.retransmit_kind == RK_FAST) begin
          res <= '{in_data.source_uniflow, DEC_STAY, 32'd0};
        end
      end
      S_EVAL: begin
        mean_for_change <= ev_change;
        if (ev_retx) begin
          sel_ok  <= 1'b1;
          sel     <= i[SEND_W-1:0];
          dec     <= DEC_RETX;
          res_rtt <= '0;
        end else if (!ev_change && !ev_best) begin
          i <= i + 1'b1;
        end
      end
      S_MEAN: if (msts.done) begin
        if (mean_for_change) begin
          sel_ok  <= 1'b1;
          sel     <= i[SEND_W-1:0];
          dec     <= DEC_CHANGE;
          res_rtt <= msts.mean;
        end else begin
          i <= i + 1'b1;
          // later uniflow wins ties
          if (!best_ok || !(best < msts.mean)) begin
            sel_ok  <= 1'b1;
            sel     <= i[SEND_W-1:0];
            best_ok <= 1'b1;
            best    <= msts.mean;
            dec     <= DEC_BEST;
            res_rtt <= msts.mean;
          end
        end
      end
      S_END: begin
        res.chosen_uniflow <= sel_ok ? sel : 3'd0;
        res.decision       <= dec;
        res.chosen_rtt     <= sel_ok ? res_rtt : 32'd0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end

endmodule

@@ rtl/mlrs_mean.sv @@
// ----------------------------------------------------------------------------
// mlrs_mean: pair RTT store and sample-weighted mean unit
// Holds per (receive, send) RTT and sample count; computes
// sum(rtt*samples)/sum(samples) for one sending uniflow, 1 if no samples.
// ----------------------------------------------------------------------------
module mlrs_mean (
  input  logic                clk,
  input  logic                rst,
  input  mlrs_pkg::pair_wr_t  wr,
  input  mlrs_pkg::mean_cmd_t cmd,
  output mlrs_pkg::mean_sts_t sts
);
  import mlrs_pkg::*;

  pair_ent_t              mem [PAIR_DEPTH];
  logic [PAIR_DEPTH-1:0]  vld;
  pair_ent_t              rd_q;
  logic                   rd_ok;
  logic                   rd_en;
  logic [PAIR_AW-1:0]     rd_addr;

  mean_state_t            state, state_next;
  logic [RCNT_W-1:0]      r;
  logic [RCNT_W-1:0]      nrecv;
  logic [SEND_W-1:0]      send;
  logic [PROD_W-1:0]      prod;
  logic [SMP_W-1:0]       smp;
  logic [WSUM_W-1:0]      wsum;
  logic [NSUM_W-1:0]      nsum;
  logic [NSUM_W-1:0]      rem;
  logic [RTT_W-1:0]       quo;
  logic [QCNT_W-1:0]      qcnt;
  logic [NSUM_W:0]        rem_sh;
  logic                   q_bit;
  logic [RTT_W-1:0]       rtt_eff;
  logic [SMP_W-1:0]       smp_eff;

  // writes land only between schedules, so no read/write overlap
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr.en) vld[wr.addr] <= 1'b1;
      if (rd_en) rd_ok <= vld[rd_addr];
    end
  end

  assign rtt_eff = rd_ok ? rd_q.rtt : '0;
  assign smp_eff = rd_ok ? rd_q.samples : '0;
  assign rd_addr = {r[RECV_W-1:0], send};

  // restoring divide, one quotient bit per cycle; high part of wsum < nsum
  assign rem_sh = {rem, quo[RTT_W-1]};
  assign q_bit  = rem_sh >= {1'b0, nsum};

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: if (cmd.start) state_next = (cmd.nrecv == '0) ? M_FIN : M_READ;
      M_READ: state_next = M_MUL;
      M_MUL:  state_next = M_ACC;
      M_ACC:  state_next = (r + 1'b1 == nrecv) ? M_DIV : M_READ;
      M_DIV:  if (nsum == '0 || qcnt == QCNT_W'(RTT_W - 1)) state_next = M_FIN;
      M_FIN:  state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    sts.done = 1'b0;
    case (state)
      M_READ: rd_en = 1'b1;
      M_FIN:  sts.done = 1'b1;
      default: ;
    endcase
  end

  assign sts.mean = (nsum == '0) ? RTT_W'(1) : quo;

  always_ff @(posedge clk) begin
    if (rst) state <= M_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: if (cmd.start) begin
        r     <= '0;
        nrecv <= cmd.nrecv;
        send  <= cmd.send;
        wsum  <= '0;
        nsum  <= '0;
        qcnt  <= '0;
      end
      M_MUL: begin
        prod <= rtt_eff * smp_eff;
        smp  <= smp_eff;
      end
      M_ACC: begin
        wsum <= wsum + WSUM_W'(prod);
        nsum <= nsum + NSUM_W'(smp);
        r    <= r + 1'b1;
        if (r + 1'b1 == nrecv) begin
          rem <= NSUM_W'(WSUM_W'(wsum + WSUM_W'(prod)) >> RTT_W);
          quo <= wsum[RTT_W-1:0] + prod[RTT_W-1:0];
        end
      end
      M_DIV: begin
        rem  <= q_bit ? NSUM_W'(rem_sh - {1'b0, nsum}) : rem_sh[NSUM_W-1:0];
        quo  <= {quo[RTT_W-2:0], q_bit};
        qcnt <= qcnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/mlrs_checker.sv @@
// ----------------------------------------------------------------------------
// mlrs_checker: port-level checks for the path scheduler
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module mlrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input mlrs_pkg::rsp_t out_data,
  input logic           out_valid,
  input logic           out_stall
);
  import mlrs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  a_default_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.decision == DEC_DEFAULT |->
      out_data.chosen_uniflow == 3'd0 && out_data.chosen_rtt == 32'd0)
    else $error("default decision carries a path");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.decision == DEC_WR_DONE |->
      out_data.chosen_uniflow == 3'd0 && out_data.chosen_rtt == 32'd0)
    else $error("write result not clean");

  a_rtt_only_on_mean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.chosen_rtt != 32'd0 |->
      out_data.decision == DEC_CHANGE || out_data.decision == DEC_BEST)
    else $error("rtt reported without a mean decision");

endmodule

bind multipath_lowest_rtt_scheduler_unit mlrs_checker u_mlrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
